/* rtl/pwt_pkg.sv */
// Package for the PID regulator with twiddle tuning.
// Shared constants, request codes and sequencer states; no dependencies.
package pwt_pkg;

  localparam int unsigned GainBitsDef   = 24;
  localparam int unsigned SampleBitsDef = 16;
  localparam int unsigned CountBitsDef  = 16;
  localparam int unsigned CfgAddrBits   = 4;
  localparam int unsigned SqBits        = 48;

  // Step scale factors, Q.16
  localparam logic [16:0] FUpBig   = 17'd72090;
  localparam logic [16:0] FUpSmall = 17'd68813;
  localparam logic [16:0] FDown    = 17'd62259;

  localparam logic [23:0] StepLimitReset = 24'd66;

  typedef enum logic [1:0] {
    REQ_SAMPLE  = 2'd0,
    REQ_TUNE    = 2'd1,
    REQ_RESTART = 2'd2,
    REQ_NONE    = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    REG_P     = 2'd0,
    REG_I     = 2'd1,
    REG_D     = 2'd2,
    REG_LIMIT = 2'd3
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_S_PROD0,
    ST_S_PROD1,
    ST_S_PROD2,
    ST_S_SQ,
    ST_S_FIN,
    ST_T_DIV,
    ST_T_TWID,
    ST_T_SCALE,
    ST_T_DONE,
    ST_R_STEP,
    ST_OUT,
    ST_T_MUL,
    ST_T_STEP,
    ST_R_DIV3
  } state_e;

endpackage

/* rtl/pwt_if.sv */
// Valid/ready channel carrying one word.
// Depends on nothing; payload type is a parameter.
interface pwt_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/pwt_div.sv */
// Restoring divider, one quotient bit per cycle.
// Depends on pwt_pkg.
module pwt_div
  import pwt_pkg::*;
#(
  parameter int unsigned NumBits = 48,
  parameter int unsigned DenBits = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [NumBits-1:0] num_i,
  input  logic [DenBits-1:0] den_i,
  output logic               busy_o,
  output logic [NumBits-1:0] quo_o
);
  localparam int unsigned CntBits = $clog2(NumBits + 1);

  logic [NumBits-1:0] quo_q, quo_d;
  logic [DenBits:0]   rem_q, rem_d;
  logic [DenBits-1:0] den_q, den_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic [DenBits:0]   trial;

  // Shift in one numerator bit and try a subtract
  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    den_d = den_q;
    cnt_d = cnt_q;
    trial = {rem_q[DenBits-1:0], quo_q[NumBits-1]};
    if (start_i) begin
      quo_d = num_i;
      rem_d = '0;
      den_d = den_i;
      cnt_d = CntBits'(NumBits);
    end else if (cnt_q != '0) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[NumBits-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NumBits-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = (cnt_q != '0);
  assign quo_o  = quo_q;
endmodule

/* rtl/pid_with_twiddle_tuning_top.sv */
// Top level of the PID regulator with twiddle gain tuning.
// Depends on pwt_pkg, pwt_if and pwt_div.
//
//  channel   dir   payload
//  req       in    req_type, error_sample
//  res       out   drive_value, gains, mean_sq_error, tuning_done, min/max
//  apb       in    four 24-bit registers at 4*i
//
// A sample passes through one shared 34x34 multiplier (three PID products, then the
// square). A tune runs the bit-serial divider for the mean (48 quotient bits, one
// a cycle), then step scaling through the same multiplier; with no samples the
// divider is not started. A restart sets the P step to gain/3 by reciprocal
// multiply. The result register holds a word while the sink stalls; the core
// then holds in its output state. Reset is asynchronous.
module pid_with_twiddle_tuning_top
  import pwt_pkg::*;
#(
  parameter int unsigned GAIN_BITS   = GainBitsDef,
  parameter int unsigned SAMPLE_BITS = SampleBitsDef,
  parameter int unsigned COUNT_BITS  = CountBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  pwt_if.sink                    req_i,
  pwt_if.source                  res_o,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CfgAddrBits-1:0] paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  localparam int unsigned G = GAIN_BITS;
  localparam int unsigned S = SAMPLE_BITS;
  localparam int unsigned C = COUNT_BITS;
  localparam int unsigned ProdBits = 2 * 34;
  // Reciprocal of three, ceil(2^(G+1)/3), exact for magnitudes up to 2^(G-1)
  localparam logic [33:0] Recip3 = 34'(((longint'(1) << (G + 1)) + 2) / 3);

  // Configuration registers
  logic [G-1:0] cfg_q [4];
  logic         cfg_we;
  reg_e         cfg_idx;
  assign cfg_idx = reg_e'(paddr[3:2]);
  assign cfg_we  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;
  assign prdata  = (paddr[1:0] == 2'b00) ? 32'(cfg_q[cfg_idx]) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q[0] <= '0;
      cfg_q[1] <= '0;
      cfg_q[2] <= '0;
      cfg_q[3] <= G'(StepLimitReset);
    end else if (cfg_we) begin
      cfg_q[cfg_idx] <= pwdata[G-1:0];
    end
  end

  // Controller state
  state_e state_q, state_d;
  logic signed [S-1:0]  err_q, prev_q, min_q, max_q;
  logic signed [31:0]   integ_q;
  logic [SqBits-1:0]    sq_q;
  logic [C-1:0]         cnt_q;
  logic signed [G-1:0]  gain_q [3];
  logic signed [G-1:0]  step_q [3];
  logic [31:0]          best_q;
  logic                 bestk_q, done_q;
  logic [1:0]           phase_q, idx_q;
  logic signed [ProdBits-1:0] acc_q;
  logic signed [ProdBits-1:0] prod_q;
  logic [31:0]          mean_q;
  logic [1:0]           sfac_q;
  logic [1:0]           six_q;

  // Core result values
  logic signed [31:0]   drive_q;
  logic [31:0]          mout_q;

  // Output register
  logic                 ovalid_q;
  logic                 res_load;
  logic signed [31:0]   od_q;
  logic signed [G-1:0]  op_q, oi_q, odg_q;
  logic [31:0]          om_q;
  logic                 odone_q;
  logic signed [S-1:0]  olo_q, ohi_q;

  // Shared multiplier operands
  logic signed [33:0] mul_a, mul_b;
  always_ff @(posedge clk_i) prod_q <= mul_a * mul_b;

  // Divider for the mean
  logic              div_start, div_busy;
  logic [SqBits-1:0] div_quo;
  pwt_div #(.NumBits(SqBits), .DenBits(C)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (sq_q),
    .den_i  (cnt_q),
    .busy_o (div_busy),
    .quo_o  (div_quo)
  );

  logic accept;
  assign accept    = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == ST_IDLE);
  assign div_start = (state_q == ST_IDLE) && accept && (req_e'(req_i.data.req_type) == REQ_TUNE)
                     && (cnt_q != '0);
  assign res_load  = (state_q == ST_OUT) && (!ovalid_q || res_o.ready);

  logic [1:0] ix;
  assign ix = (idx_q == 2'd3) ? 2'd0 : idx_q;

  // Helpers
  function automatic logic signed [G-1:0] sat_g(input logic signed [G+2:0] v);
    logic signed [G+2:0] hi, lo;
    hi = (G+3)'({1'b0, {(G-1){1'b1}}});
    lo = ~hi;
    if (v > hi) return hi[G-1:0];
    if (v < lo) return lo[G-1:0];
    return v[G-1:0];
  endfunction

  logic better;
  assign better = mean_q < best_q;

  logic signed [G+2:0] step_sum;
  assign step_sum = (G+3)'(step_q[0]) + (G+3)'(step_q[1]) + (G+3)'(step_q[2]);

  // Magnitude of the proportional gain and its third, truncated toward zero
  logic signed [G:0]   r3_ext, r3_mag;
  logic signed [G-1:0] div3;
  assign r3_ext = (G+1)'($signed(cfg_q[0]));
  assign r3_mag = r3_ext[G] ? -r3_ext : r3_ext;
  assign div3   = prod_q[G+1 +: G];

  // Scaled step from the product: round half up, floor shift, saturate
  logic signed [ProdBits-1:0] rnd;
  logic signed [ProdBits-1:0] shr;
  logic signed [G+2:0]        scaled;
  always_comb begin
    rnd = prod_q + ProdBits'(32768);
    shr = rnd >>> 16;
    if (shr > ProdBits'((1 << (G-1)) - 1)) scaled = (G+3)'((1 << (G-1)) - 1);
    else if (shr < -ProdBits'(1 << (G-1))) scaled = -(G+3)'(1 << (G-1));
    else scaled = shr[G+2:0];
  end

  // Drive value from the accumulator
  logic signed [ProdBits-1:0] neg_acc, nshr;
  logic signed [31:0]         drive_sat;
  always_comb begin
    neg_acc = -acc_q;
    nshr    = neg_acc >>> 10;
    if (nshr > ProdBits'(32'sh7fffffff)) drive_sat = 32'sh7fffffff;
    else if (nshr < -ProdBits'(33'sh080000000)) drive_sat = 32'sh80000000;
    else drive_sat = nshr[31:0];
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (req_e'(req_i.data.req_type))
            REQ_SAMPLE:  state_d = ST_S_PROD0;
            REQ_TUNE:    state_d = ST_T_DIV;
            REQ_RESTART: state_d = ST_R_STEP;
            default:     state_d = ST_OUT;
          endcase
        end
      end
      ST_S_PROD0: state_d = ST_S_PROD1;
      ST_S_PROD1: state_d = ST_S_PROD2;
      ST_S_PROD2: state_d = ST_S_SQ;
      ST_S_SQ:    state_d = ST_S_FIN;
      ST_S_FIN:   state_d = ST_OUT;
      ST_T_DIV:   if (!div_busy && !div_start) state_d = ST_T_TWID;
      ST_T_TWID:  state_d = ST_T_SCALE;
      ST_T_SCALE: state_d = ST_T_MUL;
      ST_T_MUL:   state_d = ST_T_STEP;
      ST_T_STEP:  state_d = ST_T_DONE;
      ST_T_DONE:  state_d = ST_OUT;
      ST_R_STEP:  state_d = ST_R_DIV3;
      ST_R_DIV3:  state_d = ST_OUT;
      ST_OUT:     if (res_load) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_S_PROD0: begin
        mul_a = 34'(gain_q[0]);
        mul_b = 34'(err_q);
      end
      ST_S_PROD1: begin
        mul_a = 34'(gain_q[1]);
        mul_b = 34'(integ_q);
      end
      ST_S_PROD2: begin
        mul_a = 34'(gain_q[2]);
        mul_b = 34'(err_q) - 34'(prev_q);
      end
      ST_S_SQ: begin
        mul_a = 34'(err_q);
        mul_b = 34'(err_q);
      end
      ST_T_MUL: begin
        mul_a = 34'(step_q[six_q]);
        unique case (sfac_q)
          2'd1:    mul_b = 34'(FUpBig);
          2'd2:    mul_b = 34'(FUpSmall);
          default: mul_b = 34'(FDown);
        endcase
      end
      ST_R_STEP: begin
        mul_a = 34'(r3_mag);
        mul_b = Recip3;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  logic signed [S-1:0] e_in;
  assign e_in = req_i.data.error_sample;
  logic signed [32:0] integ_sum;
  assign integ_sum = 33'(integ_q) + 33'(err_q);
  logic [SqBits:0] sq_sum;
  assign sq_sum = {1'b0, sq_q} + (SqBits+1)'(prod_q[2*S-1:0]);
  logic scale_pend_q;

  // Datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_q    <= '0;
      drive_q  <= '0;
      mout_q   <= '0;
      acc_q    <= '0;
      mean_q   <= '0;
      prev_q   <= '0;
      integ_q  <= '0;
      sq_q     <= '0;
      cnt_q    <= '0;
      min_q    <= {1'b0, {(S-1){1'b1}}};
      max_q    <= {1'b1, {(S-1){1'b0}}};
      best_q   <= '0;
      bestk_q  <= 1'b0;
      done_q   <= 1'b0;
      phase_q  <= '0;
      idx_q    <= '0;
      gain_q[0] <= '0; gain_q[1] <= '0; gain_q[2] <= '0;
      step_q[0] <= '0; step_q[1] <= '0; step_q[2] <= '0;
      scale_pend_q <= 1'b0;
      sfac_q   <= '0;
      six_q    <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: if (accept) begin
          err_q  <= e_in;
          drive_q <= '0;
          mout_q  <= '0;
          acc_q   <= '0;
        end
        ST_S_PROD1: acc_q <= prod_q;
        ST_S_PROD0: begin
          // integral first, so the product uses the updated sum
          if (integ_sum > 33'sh07fffffff) integ_q <= 32'sh7fffffff;
          else if (integ_sum < -33'sh080000000) integ_q <= 32'sh80000000;
          else integ_q <= integ_sum[31:0];
        end
        ST_S_PROD2: acc_q <= acc_q + prod_q;
        ST_S_SQ: acc_q <= acc_q + prod_q;
        ST_S_FIN: begin
          drive_q <= drive_sat;
          prev_q  <= err_q;
          sq_q    <= sq_sum[SqBits] ? {SqBits{1'b1}} : sq_sum[SqBits-1:0];
          if (cnt_q != {C{1'b1}}) cnt_q <= cnt_q + 1'b1;
          if (err_q < min_q) min_q <= err_q;
          if (err_q > max_q) max_q <= err_q;
        end
        ST_T_DIV: if (!div_busy && !div_start) begin
          if (cnt_q == '0) mean_q <= '1;
          else if (div_quo[SqBits-1:32] != '0) mean_q <= '1;
          else mean_q <= div_quo[31:0];
        end
        ST_T_TWID: begin
          mout_q <= mean_q;
          sq_q   <= '0;
          cnt_q  <= '0;
          scale_pend_q <= 1'b0;
          if (!bestk_q) begin
            bestk_q <= 1'b1;
            best_q  <= mean_q;
          end
        end
        ST_T_SCALE: begin
          // best known now set; compare against stored best (first tune: equal)
          six_q <= ix;
          if (!done_q) begin
            unique case (phase_q)
              2'd1: begin
                if (better && bestk_q) begin
                  best_q  <= mean_q;
                  sfac_q  <= 2'd1;
                  scale_pend_q <= 1'b1;
                  idx_q   <= (ix == 2'd2) ? 2'd0 : ix + 1'b1;
                  phase_q <= 2'd0;
                end else begin
                  gain_q[ix] <= sat_g((G+3)'(gain_q[ix]) - ((G+3)'(step_q[ix]) <<< 1));
                  phase_q <= 2'd2;
                end
              end
              2'd2: begin
                if (better && bestk_q) begin
                  best_q <= mean_q;
                  sfac_q <= 2'd2;
                end else begin
                  gain_q[ix] <= sat_g((G+3)'(gain_q[ix]) + (G+3)'(step_q[ix]));
                  sfac_q <= 2'd3;
                end
                scale_pend_q <= 1'b1;
                idx_q   <= (ix == 2'd2) ? 2'd0 : ix + 1'b1;
                phase_q <= 2'd0;
              end
              default: begin
                gain_q[ix] <= sat_g((G+3)'(gain_q[ix]) + (G+3)'(step_q[ix]));
                idx_q   <= ix;
                phase_q <= 2'd1;
              end
            endcase
          end
        end
        ST_T_STEP: begin
          // write back the scaled step of the gain just tuned
          if (scale_pend_q) step_q[six_q] <= scaled[G-1:0];
        end
        ST_T_DONE: begin
          if (!done_q) begin
            if (step_sum < $signed({3'b000, cfg_q[3]})) done_q <= 1'b1;
          end
        end
        ST_R_STEP: begin
          gain_q[0] <= cfg_q[0];
          gain_q[1] <= cfg_q[1];
          gain_q[2] <= cfg_q[2];
          step_q[1] <= G'($signed(cfg_q[1]) / 4);
          step_q[2] <= G'($signed(cfg_q[2]) / 2);
          prev_q  <= '0;
          integ_q <= '0;
          sq_q    <= '0;
          cnt_q   <= '0;
          min_q   <= {1'b0, {(S-1){1'b1}}};
          max_q   <= {1'b1, {(S-1){1'b0}}};
          best_q  <= '0;
          bestk_q <= 1'b0;
          phase_q <= '0;
          idx_q   <= '0;
          done_q  <= 1'b0;
        end
        ST_R_DIV3: begin
          // restore the sign of the truncated third
          step_q[0] <= gain_q[0][G-1] ? -div3 : div3;
        end
        default: ;
      endcase
    end
  end

  // Capture the finished word and hold it until the sink takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
      od_q     <= '0;
      op_q     <= '0;
      oi_q     <= '0;
      odg_q    <= '0;
      om_q     <= '0;
      odone_q  <= 1'b0;
      olo_q    <= '0;
      ohi_q    <= '0;
    end else if (res_load) begin
      ovalid_q <= 1'b1;
      od_q     <= drive_q;
      op_q     <= gain_q[0];
      oi_q     <= gain_q[1];
      odg_q    <= gain_q[2];
      om_q     <= mout_q;
      odone_q  <= done_q;
      olo_q    <= min_q;
      ohi_q    <= max_q;
    end else if (res_o.ready) begin
      ovalid_q <= 1'b0;
    end
  end

  assign res_o.valid = ovalid_q;
  assign res_o.data.drive_value   = od_q;
  assign res_o.data.p_gain_now    = op_q;
  assign res_o.data.i_gain_now    = oi_q;
  assign res_o.data.d_gain_now    = odg_q;
  assign res_o.data.mean_sq_error = om_q;
  assign res_o.data.tuning_done   = odone_q;
  assign res_o.data.lowest_error  = olo_q;
  assign res_o.data.highest_error = ohi_q;

  // Assertions
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.ready |-> (state_q == ST_IDLE)) else $error("ready outside idle");
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> (state_q == ST_T_DIV)) else $error("divider busy outside tune");
  a_min_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) |-> (min_q <= max_q)) else $error("min above max");
endmodule

/* dv/tb.sv */
// Testbench for the PID regulator with twiddle gain tuning.
// Depends on pwt_pkg, pwt_if and pid_with_twiddle_tuning_top; checks every word
// against a fixed-point PID and twiddle predictor, some phases with random idling.
`timescale 1ns / 100ps

module tb;
  import pwt_pkg::*;

  typedef struct packed {
    req_e               req_type;
    logic signed [15:0] error_sample;
  } pid_req_t;

  typedef struct packed {
    logic signed [31:0] drive_value;
    logic signed [23:0] p_gain_now;
    logic signed [23:0] i_gain_now;
    logic signed [23:0] d_gain_now;
    logic [31:0]        mean_sq_error;
    logic               tuning_done;
    logic signed [15:0] lowest_error;
    logic signed [15:0] highest_error;
  } pid_res_t;

  typedef struct {
    req_e    kind;
    int      err;
    bit      typed;
    longint  drive;
    longint  mean;
  } dir_row_t;

  localparam longint SqMax  = (longint'(1) << 48) - 1;
  localparam int     Settle = 100;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  pwt_if #(.payload_t(pid_req_t)) req_ch ();
  pwt_if #(.payload_t(pid_res_t)) res_ch ();

  pid_with_twiddle_tuning_top uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_ch.sink),
    .res_o   (res_ch.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor state
  longint cfg_gain [3];
  longint cfg_limit;
  longint prev_err, err_integ, sq_sum, n_samples, min_err, max_err;
  longint gains [3];
  longint steps [3];
  longint best_mean;
  bit     best_valid;
  int     phase_now, idx_now;
  bit     tuned_out;

  pid_res_t expected_q[$];
  int       n_fail;
  int       send_idle_pct;
  int       recv_stall_pct;

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  function automatic longint sat_to(longint v, int bits);
    longint hi;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic longint scaled_step(longint s, longint f);
    return sat_to((s * f + 32768) >>> 16, 24);
  endfunction

  function automatic void clear_run();
    prev_err   = 0;
    err_integ  = 0;
    sq_sum     = 0;
    n_samples  = 0;
    min_err    = 32767;
    max_err    = -32768;
    best_mean  = 0;
    best_valid = 0;
    phase_now  = 0;
    idx_now    = 0;
    tuned_out  = 0;
  endfunction

  // One twiddle phase on the current gain; returns the mean squared error
  function automatic longint twiddle_phase();
    longint mean;
    int     i;
    bit     better;
    i = idx_now;
    if (n_samples == 0) mean = 64'hFFFF_FFFF;
    else begin
      mean = sq_sum / n_samples;
      if (mean > 64'hFFFF_FFFF) mean = 64'hFFFF_FFFF;
    end
    if (!best_valid) begin
      best_mean  = mean;
      best_valid = 1;
    end
    sq_sum    = 0;
    n_samples = 0;
    if (tuned_out) return mean;
    better = mean < best_mean;
    if (phase_now == 1) begin
      if (better) begin
        best_mean = mean;
        steps[i]  = scaled_step(steps[i], FUpBig);
        idx_now   = (i + 1) % 3;
        phase_now = 0;
      end else begin
        gains[i]  = sat_to(gains[i] - 2 * steps[i], 24);
        phase_now = 2;
      end
    end else if (phase_now == 2) begin
      if (better) begin
        best_mean = mean;
        steps[i]  = scaled_step(steps[i], FUpSmall);
      end else begin
        gains[i] = sat_to(gains[i] + steps[i], 24);
        steps[i] = scaled_step(steps[i], FDown);
      end
      idx_now   = (i + 1) % 3;
      phase_now = 0;
    end else begin
      gains[i]  = sat_to(gains[i] + steps[i], 24);
      phase_now = 1;
    end
    if (steps[0] + steps[1] + steps[2] < cfg_limit) tuned_out = 1;
    return mean;
  endfunction

  function automatic pid_res_t predict_pid(pid_req_t w);
    longint   e, d, acc, drv, mean;
    pid_res_t r;
    drv  = 0;
    mean = 0;
    case (w.req_type)
      REQ_SAMPLE: begin
        e         = longint'(w.error_sample);
        d         = e - prev_err;
        prev_err  = e;
        err_integ = sat_to(err_integ + e, 32);
        sq_sum    = sq_sum + e * e;
        if (sq_sum > SqMax) sq_sum = SqMax;
        if (n_samples < 65535) n_samples++;
        if (e < min_err) min_err = e;
        if (e > max_err) max_err = e;
        acc = gains[0] * e + gains[1] * err_integ + gains[2] * d;
        drv = sat_to((-acc) >>> 10, 32);
      end
      REQ_TUNE: mean = twiddle_phase();
      REQ_RESTART: begin
        for (int k = 0; k < 3; k++) gains[k] = cfg_gain[k];
        steps[0] = gains[0] / 3;
        steps[1] = gains[1] / 4;
        steps[2] = gains[2] / 2;
        clear_run();
      end
      default: ;
    endcase
    r.drive_value   = drv[31:0];
    r.p_gain_now    = gains[0][23:0];
    r.i_gain_now    = gains[1][23:0];
    r.d_gain_now    = gains[2][23:0];
    r.mean_sq_error = mean[31:0];
    r.tuning_done   = tuned_out;
    r.lowest_error  = min_err[15:0];
    r.highest_error = max_err[15:0];
    return r;
  endfunction

  // Drive one word; called and returning at a falling edge
  task automatic send_word(pid_req_t w, bit typed = 0, longint drv = 0, longint mean = 0);
    pid_res_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= w;
    do @(posedge clk_i); while (!req_ch.ready);
    r = predict_pid(w);
    if (typed) begin
      r.drive_value   = drv[31:0];
      r.mean_sq_error = mean[31:0];
    end
    expected_q.push_back(r);
    @(negedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, longint value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 4'(idx) << 2;
    pwdata  <= 32'(value) & 32'h00FF_FFFF;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_LIMIT) cfg_limit = value & 64'hFF_FFFF;
    else cfg_gain[idx] = sat_to(value, 24);
  endtask

  // Hold until every expected word has come, then let a tune run out
  task automatic drain_block();
    req_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (Settle) @(negedge clk_i);
  endtask

  task automatic set_gains(longint p, longint i, longint d, longint lim);
    write_reg(REG_P, p);
    write_reg(REG_I, i);
    write_reg(REG_D, d);
    write_reg(REG_LIMIT, lim);
  endtask

  function automatic logic signed [15:0] rand_error();
    if ($urandom_range(99) < 75) return 16'($signed($urandom_range(2048)) - 1024);
    return 16'($urandom);
  endfunction

  // Mostly sample runs closed by a tune, sometimes a restart, some noise
  task automatic random_items(int count, int pause_at);
    pid_req_t w;
    int n = 0;
    while (n < count) begin
      if (n >= pause_at && pause_at >= 0) begin
        drain_block();
        pause_at = -1;
      end
      if ($urandom_range(99) < 15) begin
        w.req_type     = req_e'($urandom_range(3));
        w.error_sample = 16'($urandom);
        send_word(w);
        n++;
      end else begin
        if ($urandom_range(99) < 12) begin
          w.req_type     = REQ_RESTART;
          w.error_sample = 16'($urandom);
          send_word(w);
          n++;
        end
        repeat ($urandom_range(1, 6)) begin
          w.req_type     = REQ_SAMPLE;
          w.error_sample = rand_error();
          send_word(w);
          n++;
        end
        w.req_type     = REQ_TUNE;
        w.error_sample = 16'($urandom);
        send_word(w);
        n++;
      end
    end
  endtask

  // Randomize receiver stalls
  always @(negedge clk_i) begin
    res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each delivered word with the oldest expectation
  always @(posedge clk_i) begin
    pid_res_t ex, got;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      got = res_ch.data;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected word %h", $time, got);
        n_fail++;
      end else begin
        ex = expected_q.pop_front();
        if (got.drive_value !== ex.drive_value) begin
          $display("%0t: drive_value exp %0d got %0d", $time, ex.drive_value, got.drive_value);
          n_fail++;
        end
        if (got.p_gain_now !== ex.p_gain_now) begin
          $display("%0t: p_gain_now exp %0d got %0d", $time, ex.p_gain_now, got.p_gain_now);
          n_fail++;
        end
        if (got.i_gain_now !== ex.i_gain_now) begin
          $display("%0t: i_gain_now exp %0d got %0d", $time, ex.i_gain_now, got.i_gain_now);
          n_fail++;
        end
        if (got.d_gain_now !== ex.d_gain_now) begin
          $display("%0t: d_gain_now exp %0d got %0d", $time, ex.d_gain_now, got.d_gain_now);
          n_fail++;
        end
        if (got.mean_sq_error !== ex.mean_sq_error) begin
          $display("%0t: mean_sq_error exp %h got %h", $time, ex.mean_sq_error,
                   got.mean_sq_error);
          n_fail++;
        end
        if (got.tuning_done !== ex.tuning_done) begin
          $display("%0t: tuning_done exp %b got %b", $time, ex.tuning_done, got.tuning_done);
          n_fail++;
        end
        if (got.lowest_error !== ex.lowest_error) begin
          $display("%0t: lowest_error exp %0d got %0d", $time, ex.lowest_error,
                   got.lowest_error);
          n_fail++;
        end
        if (got.highest_error !== ex.highest_error) begin
          $display("%0t: highest_error exp %0d got %0d", $time, ex.highest_error,
                   got.highest_error);
          n_fail++;
        end
      end
    end
  end

  // Stop a hung run
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    dir_row_t rows[$];
    pid_req_t w;
    n_fail         = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    req_ch.valid   = 1'b0;
    req_ch.data    = '0;
    res_ch.ready   = 1'b1;
    cfg_gain       = '{0, 0, 0};
    cfg_limit      = 66;
    gains          = '{0, 0, 0};
    steps          = '{0, 0, 0};
    clear_run();
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: extremes, empty tune, unused request, every twiddle phase
    rows = '{
      '{REQ_TUNE,    0,      1, 0, 64'hFFFF_FFFF},
      '{REQ_NONE,    -1,     1, 0, 0},
      '{REQ_SAMPLE,  32767,  1, 0, 0},
      '{REQ_SAMPLE,  -32768, 1, 0, 0},
      '{REQ_RESTART, 0,      1, 0, 0},
      '{REQ_TUNE,    0,      1, 0, 64'hFFFF_FFFF},
      '{REQ_SAMPLE,  32767,  0, 0, 0},
      '{REQ_SAMPLE,  -32768, 0, 0, 0},
      '{REQ_SAMPLE,  32767,  0, 0, 0},
      '{REQ_SAMPLE,  0,      0, 0, 0},
      '{REQ_TUNE,    0,      0, 0, 0},
      '{REQ_SAMPLE,  -1,     0, 0, 0},
      '{REQ_SAMPLE,  1,      0, 0, 0},
      '{REQ_TUNE,    0,      0, 0, 0},
      '{REQ_SAMPLE,  1000,   0, 0, 0},
      '{REQ_TUNE,    0,      0, 0, 0},
      '{REQ_SAMPLE,  -500,   0, 0, 0},
      '{REQ_TUNE,    0,      0, 0, 0},
      '{REQ_NONE,    32767,  0, 0, 0},
      '{REQ_RESTART, 0,      1, 0, 0},
      '{REQ_SAMPLE,  -32768, 0, 0, 0}
    };
    set_gains(8388607, -8388608, 8388607, 66);
    foreach (rows[k]) begin
      w.req_type     = rows[k].kind;
      w.error_sample = 16'(rows[k].err);
      send_word(w, rows[k].typed, rows[k].drive, rows[k].mean);
    end
    drain_block();

    // Random phases, each with its own gains, limit and idling
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_gains($urandom_range(200000), $urandom_range(50000), $urandom_range(100000), 66);
        1: set_gains(-8388608, -8388608, -8388608, 0);
        2: set_gains(8388607, 8388607, 8388607, 24'hFF_FFFF);
        3: set_gains(sat_to(longint'($signed(24'($urandom))), 24),
                     sat_to(longint'($signed(24'($urandom))), 24),
                     sat_to(longint'($signed(24'($urandom))), 24), $urandom_range(2000));
        default: set_gains(0, 0, 0, $urandom_range(100));
      endcase
      case (ph)
        1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
        3: begin send_idle_pct = 22; recv_stall_pct = 22; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      w.req_type     = REQ_RESTART;
      w.error_sample = '0;
      send_word(w);
      random_items(120, (ph == 2) ? 60 : -1);
      drain_block();
    end

    if (n_fail == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
